### rtl/core/ucfd_pkg.sv
package ucfd_pkg;

   localparam int ByteW   = 8;
   localparam int WinLen  = 18;
   localparam int CkPos   = 17;
   localparam int FillW   = 5;
   localparam int SumW    = 13;
   localparam int CanIdW  = 11;
   localparam int DataW   = 32;

   localparam logic [ByteW-1:0] Sync0 = 8'hF0;
   localparam logic [ByteW-1:0] Sync1 = 8'h55;
   localparam logic [ByteW-1:0] Sync2 = 8'hAA;

   typedef logic [ByteW-1:0] byte_type;
   typedef logic [SumW-1:0]  sum_type;
   typedef logic [FillW-1:0] fill_type;

   typedef struct packed {
      logic     full;
      byte_type head0;
      byte_type head1;
      byte_type head2;
      sum_type  body_sum;
      byte_type check_byte;
   } check_in_type;

   function automatic byte_type fold_checksum(sum_type s);
      logic [ByteW:0] c1;
      logic [ByteW:0] c2;
      c1 = {1'b0, s[ByteW-1:0]} + {{(2*ByteW+1-SumW){1'b0}}, s[SumW-1:ByteW]};
      c2 = {1'b0, c1[ByteW-1:0]} + {{ByteW{1'b0}}, c1[ByteW]};
      return byte_type'(~c2[ByteW-1:0] + 8'd1);
   endfunction

endpackage

### rtl/core/ucfd_if.sv
interface ucfd_req_if;
   logic                     valid;
   logic                     ready;
   logic [ucfd_pkg::ByteW-1:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

interface ucfd_rsp_if;
   logic                        valid;
   logic                        ready;
   logic                        frame_found;
   logic [ucfd_pkg::CanIdW-1:0] can_id;
   logic [ucfd_pkg::DataW-1:0]  data_high;
   logic [ucfd_pkg::DataW-1:0]  data_low;

   modport source (output valid, output frame_found, output can_id,
                   output data_high, output data_low, input ready);
   modport sink   (input valid, input frame_found, input can_id,
                   input data_high, input data_low, output ready);
endinterface

### rtl/core/ucfd_cell.sv
module ucfd_cell (
   input  logic               clock,
   input  logic               advance,
   input  ucfd_pkg::byte_type d_in,
   output ucfd_pkg::byte_type d_out
);

   ucfd_pkg::byte_type byte_ff;
   ucfd_pkg::byte_type byte_in;

   assign byte_in = advance ? d_in : byte_ff;
   assign d_out   = byte_ff;

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
   end

endmodule

### rtl/core/ucfd_check.sv
module ucfd_check (
   input  ucfd_pkg::check_in_type chk,
   output logic                   hit
);

   logic sync_ok;
   logic sum_ok;

   assign sync_ok = (chk.head0 == ucfd_pkg::Sync0) && (chk.head1 == ucfd_pkg::Sync1)
                 && (chk.head2 == ucfd_pkg::Sync2);
   assign sum_ok  = ucfd_pkg::fold_checksum(chk.body_sum) == chk.check_byte;
   assign hit     = chk.full && sync_ok && sum_ok;

endmodule

### rtl/core/usb_can_frame_deframer.sv
// Sync-word frame deframer: bytes enter a row of 18 shift cells, one byte per
// transfer, and a running sum of the window tracks the checksum. A window that
// starts F0 55 AA and ends in the folded two's-complement sum of its first 17
// bytes yields frame_found with the CAN id and eight data bytes, and the window
// then starts empty. Every request transfer gives exactly one registered
// response; a new byte is taken every cycle while the output register is
// empty or being drained, so the sustained rate is one byte per clock while
// the response side keeps draining; the cell row and the sum step together.
module usb_can_frame_deframer (
   input logic         clock,
   input logic         reset,
   ucfd_req_if.sink    req_chan,
   ucfd_rsp_if.source  rsp_chan
);

   localparam int Last = ucfd_pkg::WinLen - 1;

   ucfd_pkg::byte_type     win_q [ucfd_pkg::WinLen];
   ucfd_pkg::fill_type     fill_ff;
   ucfd_pkg::fill_type     fill_in;
   ucfd_pkg::sum_type      sum_ff;
   ucfd_pkg::sum_type      sum_in;
   ucfd_pkg::sum_type      body_sum;
   ucfd_pkg::byte_type     drop_byte;
   ucfd_pkg::check_in_type chk;
   logic                   advance;
   logic                   full_now;
   logic                   hit;

   logic                          rsp_valid_ff;
   logic                          rsp_valid_in;
   logic                          found_ff;
   logic [ucfd_pkg::CanIdW-1:0]   can_id_ff;
   logic [ucfd_pkg::DataW-1:0]    data_high_ff;
   logic [ucfd_pkg::DataW-1:0]    data_low_ff;

   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign advance        = req_chan.valid && req_chan.ready;

   generate
      for (genvar i = 0; i < ucfd_pkg::WinLen; i++) begin : g_cell
         ucfd_pkg::byte_type d_in;
         if (i == Last) begin : g_tail
            assign d_in = req_chan.rx_byte;
         end else begin : g_body
            assign d_in = win_q[i+1];
         end
         ucfd_cell u_cell (
            .clock   (clock),
            .advance (advance),
            .d_in    (d_in),
            .d_out   (win_q[i])
         );
      end
   endgenerate

   // window after this byte: cell i takes cell i+1, newest byte in the last cell
   assign full_now  = fill_ff == ucfd_pkg::FillW'(ucfd_pkg::WinLen);
   assign drop_byte = full_now ? win_q[0] : '0;
   assign body_sum  = sum_ff - {{(ucfd_pkg::SumW-ucfd_pkg::ByteW){1'b0}}, drop_byte};

   assign chk.full       = fill_ff >= ucfd_pkg::FillW'(Last);
   assign chk.head0      = win_q[1];
   assign chk.head1      = win_q[2];
   assign chk.head2      = win_q[3];
   assign chk.body_sum   = body_sum;
   assign chk.check_byte = req_chan.rx_byte;

   ucfd_check u_check (
      .chk (chk),
      .hit (hit)
   );

   always_comb begin
      fill_in = fill_ff;
      sum_in  = sum_ff;
      if (advance) begin
         if (hit) begin
            fill_in = '0;
            sum_in  = '0;
         end else begin
            fill_in = full_now ? fill_ff : fill_ff + 1'b1;
            sum_in  = body_sum
                    + {{(ucfd_pkg::SumW-ucfd_pkg::ByteW){1'b0}}, req_chan.rx_byte};
         end
      end
   end

   assign rsp_valid_in = advance || (rsp_valid_ff && !rsp_chan.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff      <= '0;
         sum_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         fill_ff      <= fill_in;
         sum_ff       <= sum_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         found_ff <= hit;
         if (hit) begin
            can_id_ff    <= {win_q[5], win_q[6][ucfd_pkg::ByteW-1 -: 3]};
            data_high_ff <= {win_q[10], win_q[11], win_q[12], win_q[13]};
            data_low_ff  <= {win_q[14], win_q[15], win_q[16], win_q[17]};
         end else begin
            can_id_ff    <= '0;
            data_high_ff <= '0;
            data_low_ff  <= '0;
         end
      end
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.frame_found = found_ff;
   assign rsp_chan.can_id      = can_id_ff;
   assign rsp_chan.data_high   = data_high_ff;
   assign rsp_chan.data_low    = data_low_ff;

endmodule

### tb/sv/tb_usb_can_frame_deframer.sv
`timescale 1ns / 100ps

module tb_usb_can_frame_deframer;
   import ucfd_pkg::*;

   localparam int ItemTarget  = 500;
   localparam int CycleLimit  = 300000;
   localparam int DrainCycles = 10;

   typedef struct packed {
      logic              found;
      logic [CanIdW-1:0] can_id;
      logic [DataW-1:0]  data_high;
      logic [DataW-1:0]  data_low;
   } frame_report_type;

   typedef enum int {FrameGood, FrameBadCheck, FrameBadSync} frame_kind_type;

   logic clock;
   logic reset;

   ucfd_req_if req_if ();
   ucfd_rsp_if rsp_if ();

   usb_can_frame_deframer u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if)
   );

   byte_type         win_bytes [WinLen];
   int               win_fill;
   sum_type          win_sum;
   frame_report_type pending_frames [$];
   int               bytes_sent;
   int               mismatches;
   int               cycles;
   bit               no_idle;

   always begin
      clock = 1'b1;
      #4;
      clock = 1'b0;
      #4;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles == CycleLimit) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   function automatic int draw_wait();
      return no_idle ? 0 : int'($urandom_range(0, 19));
   endfunction

   function automatic byte_type folded_check(input sum_type total);
      sum_type acc;
      acc = total;
      acc = acc[ByteW-1:0] + (acc >> ByteW);
      acc = acc[ByteW-1:0] + (acc >> ByteW);
      return byte_type'(8'h00 - acc[ByteW-1:0]);
   endfunction

   // shift one byte into the window and queue the report it should produce
   task automatic shift_and_match(input byte_type b);
      frame_report_type rep;
      sum_type          body;
      rep = '0;
      if (win_fill < WinLen) begin
         win_bytes[win_fill] = b;
         win_fill++;
      end else begin
         win_sum = win_sum - win_bytes[0];
         for (int i = 0; i < WinLen - 1; i++) win_bytes[i] = win_bytes[i + 1];
         win_bytes[WinLen - 1] = b;
      end
      win_sum = win_sum + b;
      if (win_fill == WinLen && win_bytes[0] == Sync0 && win_bytes[1] == Sync1 &&
          win_bytes[2] == Sync2) begin
         body = win_sum - win_bytes[CkPos];
         if (folded_check(body) == win_bytes[CkPos]) begin
            rep.found     = 1'b1;
            rep.can_id    = {win_bytes[4], win_bytes[5][7:5]};
            rep.data_high = {win_bytes[9], win_bytes[10], win_bytes[11], win_bytes[12]};
            rep.data_low  = {win_bytes[13], win_bytes[14], win_bytes[15], win_bytes[16]};
            win_fill      = 0;
            win_sum       = '0;
         end
      end
      pending_frames.push_back(rep);
   endtask

   always @(posedge clock) begin : monitor
      frame_report_type want;
      if (!reset) begin
         if (req_if.valid && req_if.ready) shift_and_match(req_if.rx_byte);
         if (rsp_if.valid && rsp_if.ready) begin
            if (pending_frames.size() == 0) begin
               $error("response transfer with nothing pending");
               mismatches++;
            end else begin
               want = pending_frames.pop_front();
               if (rsp_if.frame_found !== want.found) begin
                  $error("frame_found expected %0h got %0h", want.found, rsp_if.frame_found);
                  mismatches++;
               end
               if (rsp_if.can_id !== want.can_id) begin
                  $error("can_id expected %0h got %0h", want.can_id, rsp_if.can_id);
                  mismatches++;
               end
               if (rsp_if.data_high !== want.data_high) begin
                  $error("data_high expected %0h got %0h", want.data_high, rsp_if.data_high);
                  mismatches++;
               end
               if (rsp_if.data_low !== want.data_low) begin
                  $error("data_low expected %0h got %0h", want.data_low, rsp_if.data_low);
                  mismatches++;
               end
            end
         end
      end
   end

   always begin
      int stall;
      @(negedge clock);
      stall = draw_wait();
      if (stall > 0) begin
         rsp_if.ready = 1'b0;
         repeat (stall) @(negedge clock);
      end
      rsp_if.ready = 1'b1;
      do @(posedge clock); while (!(rsp_if.valid && rsp_if.ready));
   end

   task automatic send_byte(input byte_type b);
      int gap;
      gap = draw_wait();
      if (gap > 0) begin
         @(negedge clock);
         req_if.valid = 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_if.valid   = 1'b1;
      req_if.rx_byte = b;
      do @(posedge clock); while (!req_if.ready);
      bytes_sent++;
   endtask

   task automatic send_frame(input logic [CanIdW-1:0] id, input logic [DataW-1:0] hi,
                             input logic [DataW-1:0] lo, input frame_kind_type kind,
                             input int len);
      byte_type f [WinLen];
      sum_type  total;
      int       k;
      f[0] = Sync0;
      f[1] = Sync1;
      f[2] = Sync2;
      f[3] = byte_type'($urandom);
      f[4] = id[10:3];
      f[5] = {id[2:0], 5'($urandom)};
      for (int i = 6; i < 9; i++) f[i] = byte_type'($urandom);
      for (int i = 0; i < 4; i++) begin
         f[9 + i]  = hi[DataW - 1 - 8 * i -: 8];
         f[13 + i] = lo[DataW - 1 - 8 * i -: 8];
      end
      if (kind == FrameBadSync) begin
         k    = $urandom_range(0, 2);
         f[k] = f[k] ^ byte_type'(1 << $urandom_range(0, 7));
      end
      total = '0;
      for (int i = 0; i < CkPos; i++) total = total + f[i];
      f[CkPos] = folded_check(total);
      if (kind == FrameBadCheck) f[CkPos] = f[CkPos] ^ byte_type'($urandom_range(1, 255));
      for (int i = 0; i < len; i++) send_byte(f[i]);
   endtask

   task automatic send_good_random();
      send_frame(CanIdW'($urandom), $urandom, $urandom, FrameGood, WinLen);
   endtask

   // noise ahead of a frame makes the window fill and then slide
   task automatic test_fill_and_slide();
      no_idle = 1'b1;
      repeat (7) send_byte(byte_type'($urandom));
      no_idle = 1'b0;
      send_good_random();
   endtask

   task automatic test_field_extremes();
      send_frame('1, '1, '1, FrameGood, WinLen);
      send_frame('0, '0, '0, FrameGood, WinLen);
   endtask

   task automatic test_bad_frames();
      send_frame(CanIdW'($urandom), $urandom, $urandom, FrameBadCheck, WinLen);
      send_frame(CanIdW'($urandom), $urandom, $urandom, FrameBadSync, WinLen);
      send_good_random();
   endtask

   task automatic test_random_stream();
      int stop_at;
      int pick;
      stop_at = ItemTarget;
      while (bytes_sent < stop_at) begin
         no_idle = ($urandom_range(0, 3) == 0);
         pick    = $urandom_range(0, 99);
         if (pick < 60) begin
            send_good_random();
         end else if (pick < 70) begin
            send_frame(CanIdW'($urandom), $urandom, $urandom, FrameBadCheck, WinLen);
         end else if (pick < 76) begin
            send_frame(CanIdW'($urandom), $urandom, $urandom, FrameBadSync, WinLen);
         end else if (pick < 86) begin
            send_frame(CanIdW'($urandom), $urandom, $urandom, FrameGood,
                       $urandom_range(1, WinLen - 1));
         end else begin
            repeat ($urandom_range(1, 10)) begin
               case ($urandom_range(0, 4))
                  0: send_byte(Sync0);
                  1: send_byte(Sync1);
                  2: send_byte(Sync2);
                  default: send_byte(byte_type'($urandom));
               endcase
            end
         end
      end
   endtask

   initial begin
      reset          = 1'b1;
      req_if.valid   = 1'b0;
      req_if.rx_byte = '0;
      rsp_if.ready   = 1'b0;
      no_idle        = 1'b0;
      bytes_sent     = 0;
      mismatches     = 0;
      cycles         = 0;
      win_fill       = 0;
      win_sum        = '0;
      foreach (win_bytes[i]) win_bytes[i] = '0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_fill_and_slide();
      test_field_extremes();
      test_bad_frames();
      test_random_stream();

      @(negedge clock);
      req_if.valid = 1'b0;
      while (pending_frames.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
      if (mismatches == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

### filelist.f
rtl/core/ucfd_pkg.sv
rtl/core/ucfd_if.sv
rtl/core/ucfd_cell.sv
rtl/core/ucfd_check.sv
rtl/core/usb_can_frame_deframer.sv
tb/sv/tb_usb_can_frame_deframer.sv
